@@ hw/rtl/bdlp_pkg.sv @@
// Package for the button debounce / long-press / auto-repeat block.
// Holds the per-lane status and configuration structs, register indexes and reset values.
// No dependencies.
package bdlp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE_COUNT = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS_MS  = 2'd1;
    localparam logic [1:0] CFG_REPEAT_MS      = 2'd2;

    // Register reset values
    localparam logic [7:0]  DEBOUNCE_COUNT_RST = 8'd3;
    localparam logic [15:0] LONG_PRESS_MS_RST  = 16'd500;
    localparam logic [15:0] REPEAT_MS_RST      = 16'd100;

    // Fixed field widths
    localparam int NOW_BITS  = 32;
    localparam int CFG_BITS  = 16;
    localparam int IN_BYTES  = 5;
    localparam int OUT_BYTES = 1;

    // Configuration seen by every lane
    typedef struct packed {
        logic [7:0]  debounce_count;
        logic [15:0] long_press_ms;
        logic [15:0] repeat_ms;
    } cfg_t;

    // Status of one lane after a poll
    typedef struct packed {
        logic evt;
        logic long_act;
        logic level;
    } lane_status_t;

endpackage

@@ hw/rtl/bdlp_lane.sv @@
// One button lane: debounce counter, debounced level, event flag, long press and repeat timing.
// Depends on bdlp_pkg.
module bdlp_lane
    import bdlp_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 poll,
    input  logic                 raw,
    input  logic                 rd,
    input  logic [TIME_BITS-1:0] now,
    input  cfg_t                 cfg,
    output lane_status_t         status
);

    logic [7:0]           stable_polls_reg, stable_polls_next;
    logic                 clean_level_reg, clean_level_next;
    logic                 previous_raw_reg, previous_raw_next;
    logic                 event_flag_reg, event_flag_next;
    logic                 long_active_reg, long_active_next;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;
    logic [TIME_BITS-1:0] repeat_time_reg, repeat_time_next;

    logic [7:0]           stable_inc;
    logic [TIME_BITS-1:0] held_ms;
    logic [TIME_BITS-1:0] since_repeat_ms;
    logic                 long_due;
    logic                 repeat_due;
    logic                 flag_post;

    assign stable_inc      = stable_polls_reg + 8'd1;
    assign held_ms         = now - press_time_reg;
    assign since_repeat_ms = now - repeat_time_reg;
    assign long_due        = held_ms >= TIME_BITS'(cfg.long_press_ms);
    assign repeat_due      = since_repeat_ms >= TIME_BITS'(cfg.repeat_ms);

    // Poll update
    always_comb
    begin
        stable_polls_next = stable_polls_reg;
        clean_level_next  = clean_level_reg;
        previous_raw_next = previous_raw_reg;
        long_active_next  = long_active_reg;
        press_time_next   = press_time_reg;
        repeat_time_next  = repeat_time_reg;
        flag_post         = event_flag_reg;

        if (raw != previous_raw_reg)
        begin
            // level changed: restart stability count
            stable_polls_next = 8'd0;
            previous_raw_next = raw;
        end
        else if (stable_polls_reg < cfg.debounce_count)
        begin
            stable_polls_next = stable_inc;
            if (stable_inc >= cfg.debounce_count)
            begin
                if (clean_level_reg && !raw)
                begin
                    // debounced press
                    clean_level_next = 1'b0;
                    flag_post        = 1'b1;
                    press_time_next  = now;
                    long_active_next = 1'b0;
                    repeat_time_next = '0;
                end
                else if (!clean_level_reg && raw)
                begin
                    // debounced release
                    clean_level_next = 1'b1;
                    long_active_next = 1'b0;
                end
            end
        end
        else if (!clean_level_reg && long_due)
        begin
            // held: long press entry, then repeat events
            if (!long_active_reg)
            begin
                long_active_next = 1'b1;
                repeat_time_next = now;
                flag_post        = 1'b1;
            end
            else if (repeat_due)
            begin
                repeat_time_next = now;
                flag_post        = 1'b1;
            end
        end

        event_flag_next = flag_post & ~rd;
    end

    assign status.evt      = flag_post;
    assign status.long_act = long_active_next;
    assign status.level    = clean_level_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_polls_reg <= '0;
            clean_level_reg  <= 1'b0;
            previous_raw_reg <= 1'b0;
            event_flag_reg   <= 1'b0;
            long_active_reg  <= 1'b0;
            press_time_reg   <= '0;
            repeat_time_reg  <= '0;
        end
        else if (poll)
        begin
            stable_polls_reg <= stable_polls_next;
            clean_level_reg  <= clean_level_next;
            previous_raw_reg <= previous_raw_next;
            event_flag_reg   <= event_flag_next;
            long_active_reg  <= long_active_next;
            press_time_reg   <= press_time_next;
            repeat_time_reg  <= repeat_time_next;
        end
    end

endmodule

@@ hw/rtl/bdlp_merge.sv @@
// Merge stage: packs both lanes' status into one result and holds it in the output register.
// Depends on bdlp_pkg.
module bdlp_merge
    import bdlp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lane_status_t [1:0]     lane_st,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BYTES*8-1:0] m_tdata
);

    logic                   m_tvalid_reg;
    logic [OUT_BYTES*8-1:0] m_tdata_reg, m_tdata_next;

    // Output register frees up when empty or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign m_tdata_next = {2'b00,
                           lane_st[1].level,    lane_st[0].level,
                           lane_st[1].long_act, lane_st[0].long_act,
                           lane_st[1].evt,      lane_st[0].evt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

@@ hw/rtl/button_debounce_long_press_repeat.sv @@
// Two-button debouncer with long-press detection and auto-repeat. Each input transaction is
// one poll; each poll gives exactly one result transaction from the output register, carrying
// the event flags, long-press marks and debounced levels after that poll. One poll is taken
// every cycle while the output register is empty or being drained; each lane does its update
// with two parallel time subtractions. Time differences wrap modulo 2^TIME_BITS. The user
// must write configuration through cfg_we/cfg_index/cfg_data while idle, unenforced by the block.
// Depends on bdlp_pkg, bdlp_lane, bdlp_merge.
module button_debounce_long_press_repeat
    import bdlp_pkg::*;
#(
    parameter int BUTTON_COUNT = 2,
    parameter int TIME_BITS    = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // [0] raw_up, [1] raw_down, [33:2] now_ms, [34] read_up, [35] read_down
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_BYTES*8-1:0]  s_tdata,
    // [0] up_event, [1] down_event, [2] up_long, [3] down_long, [4] up_level, [5] down_level
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BYTES*8-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_data
);

    localparam int LANES = (BUTTON_COUNT < 2) ? BUTTON_COUNT : 2;

    cfg_t                 cfg_reg;
    logic                 poll;
    logic [1:0]           raw;
    logic [1:0]           rd;
    logic [TIME_BITS-1:0] now;
    lane_status_t [1:0]   lane_st;

    assign poll = s_tvalid && s_tready;
    assign raw  = s_tdata[1:0];
    assign now  = TIME_BITS'(s_tdata[NOW_BITS+1:2]);
    assign rd   = s_tdata[NOW_BITS+3:NOW_BITS+2];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_count <= DEBOUNCE_COUNT_RST;
            cfg_reg.long_press_ms  <= LONG_PRESS_MS_RST;
            cfg_reg.repeat_ms      <= REPEAT_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_COUNT: cfg_reg.debounce_count <= cfg_data[7:0];
                CFG_LONG_PRESS_MS:  cfg_reg.long_press_ms  <= cfg_data;
                CFG_REPEAT_MS:      cfg_reg.repeat_ms      <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Lanes; a lane beyond BUTTON_COUNT reports zeros
    for (genvar k = 0; k < 2; k++)
    begin : g_lane
        if (k < LANES)
        begin : g_on
            bdlp_lane #(
                .TIME_BITS (TIME_BITS)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .poll   (poll),
                .raw    (raw[k]),
                .rd     (rd[k]),
                .now    (now),
                .cfg    (cfg_reg),
                .status (lane_st[k])
            );
        end
        else
        begin : g_off
            assign lane_st[k] = '0;
        end
    end

    // Merge and output register
    bdlp_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .lane_st  (lane_st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for button_debounce_long_press_repeat: polls are driven on the
// input stream, and every status result is checked against a cycle-free model of both lanes.
// Depends on bdlp_pkg and the RTL of the block.
module tb_top;
    import bdlp_pkg::*;

    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         IN_BITS        = IN_BYTES * 8;
    localparam int         OUT_BITS       = OUT_BYTES * 8;

    // One poll as it travels on the input stream
    typedef struct packed {
        logic        read_down;
        logic        read_up;
        logic [31:0] now_ms;
        logic        raw_down;
        logic        raw_up;
    } poll_t;

    // Status after one poll, bit order as on m_tdata
    typedef struct packed {
        logic down_level;
        logic up_level;
        logic down_long;
        logic up_long;
        logic down_event;
        logic up_event;
    } status_t;

    // Per-button tracking state
    typedef struct {
        logic [7:0]  polls;
        logic        level;
        logic        prev_raw;
        logic        evt;
        logic        long_on;
        logic [31:0] t_press;
        logic [31:0] t_repeat;
    } button_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_BITS-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    // Testbench state
    poll_t   polls_todo[$];
    status_t status_due[$];
    cfg_t    model_cfg;
    button_t buttons[2];
    logic    took_in = 1'b0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      errors = 0;
    int      cycles = 0;
    int      n_polls = 0;
    int      n_settings = 0;
    int      n_press = 0;
    int      n_long = 0;
    int      n_repeat = 0;

    // Stimulus generator state
    logic [31:0] clock_ms;
    logic        gen_raw[2];
    int          gen_hold[2];
    int          dbc_eff;
    int          tick_max;
    int          hold_span;

    button_debounce_long_press_repeat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [0] raw_up, [1] raw_down, [33:2] now_ms, [34] read_up, [35] read_down
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [0] up_event, [1] down_event, [2] up_long, [3] down_long, [4] up_level, [5] down_level
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void clear_model();
        model_cfg.debounce_count = DEBOUNCE_COUNT_RST;
        model_cfg.long_press_ms  = LONG_PRESS_MS_RST;
        model_cfg.repeat_ms      = REPEAT_MS_RST;
        for (int k = 0; k < 2; k++)
        begin
            buttons[k].polls    = '0;
            buttons[k].level    = 1'b0;
            buttons[k].prev_raw = 1'b0;
            buttons[k].evt      = 1'b0;
            buttons[k].long_on  = 1'b0;
            buttons[k].t_press  = '0;
            buttons[k].t_repeat = '0;
        end
    endfunction

    // Debounce, long press and repeat for one button on one poll
    function automatic void update_button(input int k, input logic raw, input logic [31:0] t_now);
        logic [31:0] held;
        logic [31:0] since_rep;
        held      = t_now - buttons[k].t_press;
        since_rep = t_now - buttons[k].t_repeat;
        // raw edge restarts the stability count
        if (raw != buttons[k].prev_raw)
        begin
            buttons[k].polls    = '0;
            buttons[k].prev_raw = raw;
            return;
        end
        // still counting toward a stable level
        if (buttons[k].polls < model_cfg.debounce_count)
        begin
            buttons[k].polls = buttons[k].polls + 8'd1;
            if (buttons[k].polls >= model_cfg.debounce_count)
            begin
                if (buttons[k].level && !raw)
                begin
                    buttons[k].level    = 1'b0;
                    buttons[k].evt      = 1'b1;
                    buttons[k].t_press  = t_now;
                    buttons[k].long_on  = 1'b0;
                    buttons[k].t_repeat = '0;
                    n_press++;
                end
                else if (!buttons[k].level && raw)
                begin
                    buttons[k].level   = 1'b1;
                    buttons[k].long_on = 1'b0;
                end
            end
            return;
        end
        if (buttons[k].level)
            return;
        // stable and pressed: long press, then repeats
        if (held >= {16'd0, model_cfg.long_press_ms})
        begin
            if (!buttons[k].long_on)
            begin
                buttons[k].long_on  = 1'b1;
                buttons[k].t_repeat = t_now;
                buttons[k].evt      = 1'b1;
                n_long++;
            end
            else if (since_rep >= {16'd0, model_cfg.repeat_ms})
            begin
                buttons[k].t_repeat = t_now;
                buttons[k].evt      = 1'b1;
                n_repeat++;
            end
        end
    endfunction

    function automatic status_t poll_buttons(input poll_t p);
        status_t s;
        update_button(0, p.raw_up, p.now_ms);
        update_button(1, p.raw_down, p.now_ms);
        s.up_event   = buttons[0].evt;
        s.down_event = buttons[1].evt;
        s.up_long    = buttons[0].long_on;
        s.down_long  = buttons[1].long_on;
        s.up_level   = buttons[0].level;
        s.down_level = buttons[1].level;
        // read strobes clear the flag after it has been reported
        if (p.read_up)
            buttons[0].evt = 1'b0;
        if (p.read_down)
            buttons[1].evt = 1'b0;
        return s;
    endfunction

    function automatic void check_field(input string name, input logic e, input logic a);
        if (e !== a)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endfunction

    // Monitor: config writes, accepted polls and status results
    always @(posedge clk)
    begin : monitor
        poll_t   p;
        status_t e;
        status_t a;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                a = status_t'(m_tdata[5:0]);
                if (status_due.size() == 0)
                begin
                    $error("status transaction with nothing expected: %b", m_tdata);
                    errors++;
                end
                else
                begin
                    e = status_due.pop_front();
                    check_field("up_event", e.up_event, a.up_event);
                    check_field("down_event", e.down_event, a.down_event);
                    check_field("up_long", e.up_long, a.up_long);
                    check_field("down_long", e.down_long, a.down_long);
                    check_field("up_level", e.up_level, a.up_level);
                    check_field("down_level", e.down_level, a.down_level);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE_COUNT: model_cfg.debounce_count = cfg_data[7:0];
                    CFG_LONG_PRESS_MS:  model_cfg.long_press_ms  = cfg_data;
                    CFG_REPEAT_MS:      model_cfg.repeat_ms      = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                p = polls_todo.pop_front();
                status_due.push_back(poll_buttons(p));
                n_polls++;
            end
            took_in <= s_tvalid && s_tready;
        end
        else
            took_in <= 1'b0;
    end

    // Driver: input stream and output backpressure, changed on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || took_in)
            begin
                if (polls_todo.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_BITS'(polls_todo[0]);
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_poll(input logic ru, input logic rd, input logic [31:0] t,
                             input logic clr_up, input logic clr_dn);
        poll_t p;
        p.raw_up    = ru;
        p.raw_down  = rd;
        p.now_ms    = t;
        p.read_up   = clr_up;
        p.read_down = clr_dn;
        polls_todo.push_back(p);
    endtask

    // Sender stays quiet until every result is back
    task automatic wait_drained();
        while (polls_todo.size() != 0 || status_due.size() != 0 || s_tvalid)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Realistic button activity: holds of random length, some shorter than debounce
    task automatic button_poll();
        for (int k = 0; k < 2; k++)
        begin
            if (gen_hold[k] == 0)
            begin
                if ($urandom_range(99) < 70)
                    gen_raw[k] = ~gen_raw[k];
                if ($urandom_range(3) != 0)
                    gen_hold[k] = dbc_eff + $urandom_range(hold_span);
                else
                    gen_hold[k] = $urandom_range(dbc_eff + 1, 1);
            end
            else
                gen_hold[k]--;
        end
        if ($urandom_range(99) < 3)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(tick_max);
        push_poll(gen_raw[0], gen_raw[1], clock_ms,
                  $urandom_range(99) < 35, $urandom_range(99) < 35);
    endtask

    task automatic run_setting(input logic [15:0] dbc, input logic [15:0] lp, input logic [15:0] rp,
                               input int n, input int tick, input int span,
                               input int sidle, input int ridle);
        wait_drained();
        write_reg(CFG_DEBOUNCE_COUNT, dbc);
        write_reg(CFG_LONG_PRESS_MS, lp);
        write_reg(CFG_REPEAT_MS, rp);
        n_settings++;
        dbc_eff       = int'(dbc[7:0]);
        tick_max      = tick;
        hold_span     = span;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        clock_ms      = $urandom();
        for (int i = 0; i < n; i++)
        begin
            // mostly button activity, some unrelated noise
            if ($urandom_range(99) < 8)
                push_poll(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom(),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                button_poll();
        end
    endtask

    // Stimulus sequence
    initial
    begin
        clear_model();
        gen_raw[0]  = 1'b1;
        gen_raw[1]  = 1'b1;
        gen_hold[0] = 0;
        gen_hold[1] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset config, held low from reset gives long press with no press event
        send_idle_pct = 34;
        recv_idle_pct = 47;
        n_settings    = 1;
        push_poll(1'b0, 1'b0, 32'd0, 1'b1, 1'b1);
        push_poll(1'b0, 1'b0, 32'd1, 1'b0, 1'b0);
        push_poll(1'b0, 1'b0, 32'd2, 1'b0, 1'b0);
        push_poll(1'b0, 1'b0, 32'd600, 1'b1, 1'b0);
        push_poll(1'b0, 1'b0, 32'd650, 1'b1, 1'b0);
        push_poll(1'b0, 1'b0, 32'd700, 1'b1, 1'b1);
        push_poll(1'b0, 1'b1, 32'hFFFF_FFF0, 1'b0, 1'b1);
        // release both across the timestamp wrap
        push_poll(1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_poll(1'b1, 1'b1, 32'd0, 1'b0, 1'b0);
        push_poll(1'b1, 1'b1, 32'd5, 1'b0, 1'b0);
        push_poll(1'b1, 1'b1, 32'd10, 1'b1, 1'b1);
        // debounced press, bounce on the down button, then stable
        push_poll(1'b0, 1'b0, 32'hFFFF_FF00, 1'b0, 1'b0);
        push_poll(1'b0, 1'b1, 32'hFFFF_FF01, 1'b0, 1'b0);
        push_poll(1'b0, 1'b0, 32'hFFFF_FF02, 1'b0, 1'b0);
        push_poll(1'b0, 1'b0, 32'hFFFF_FF03, 1'b0, 1'b0);
        push_poll(1'b0, 1'b0, 32'hFFFF_FF04, 1'b1, 1'b0);
        push_poll(1'b0, 1'b0, 32'hFFFF_FF05, 1'b0, 1'b0);
        push_poll(1'b0, 1'b0, 32'h0000_00F4, 1'b0, 1'b1);
        push_poll(1'b0, 1'b0, 32'h0000_0158, 1'b1, 1'b1);
        push_poll(1'b0, 1'b0, 32'h0000_0159, 1'b1, 1'b1);
        push_poll(1'b1, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b0);

        // Random part, receiver-heavy idling first
        run_setting(16'd2, 16'd60, 16'd15, 300, 10, 40, 34, 47);
        run_setting(16'd1, 16'd0, 16'd0, 200, 8, 20, 34, 47);
        // unused index must leave all registers alone
        wait_drained();
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        run_setting(16'hFF05, 16'd300, 16'd50, 300, 30, 40, 47, 34);
        run_setting(16'd0, 16'd40, 16'd10, 150, 10, 20, 47, 34);
        // widest debounce and hold times, no idling from here on
        run_setting(16'd255, 16'd65535, 16'd65535, 400, 2000, 100, 0, 0);
        // lowered count after long counters, defaults again
        run_setting(16'd3, 16'd500, 16'd100, 300, 40, 60, 0, 0);
        run_setting(16'd2, 16'd20, 16'd5, 250, 6, 30, 0, 0);

        wait_drained();
        repeat (4) @(negedge clk);
        $display("Checked %0d polls over %0d register settings.", n_polls, n_settings);
        $display("Model saw %0d press events, %0d long-press entries and %0d repeats.",
                 n_press, n_long, n_repeat);
        if (errors == 0 && status_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
